// ===== src/uart_rx_tx_ring_engine_assert.svh =====
// assertion macros for the uart ring engine
`ifndef UART_RX_TX_RING_ENGINE_ASSERT_SVH
`define UART_RX_TX_RING_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define URTR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define URTR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define URTR_ASSERT(lbl, prop, msg)
`define URTR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== src/urtr_pkg.sv =====
package urtr_pkg;

	// ring sizes
	localparam int RX_DEPTH = 256;
	localparam int TX_DEPTH = 256;
	localparam int RX_AW = $clog2(RX_DEPTH);
	localparam int TX_AW = $clog2(TX_DEPTH);
	localparam int RX_LW = $clog2(RX_DEPTH + 1);
	localparam int TX_LW = $clog2(TX_DEPTH + 1);
	localparam logic [RX_LW-1:0] RX_FULL_LVL = RX_LW'(RX_DEPTH);
	localparam logic [TX_LW-1:0] TX_FULL_LVL = TX_LW'(TX_DEPTH);
	localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);
	localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);

	// scanner
	localparam int MAGIC_MAX = 8;
	localparam int MAGIC_LEN_W = 4;
	localparam logic [MAGIC_LEN_W-1:0] MAGIC_LEN_CAP = MAGIC_LEN_W'(MAGIC_MAX);

	// configuration port
	localparam int CFG_IW = 1;
	localparam int CFG_DW = 64;
	localparam logic [CFG_IW-1:0] REG_MAGIC_CHARS = 1'b0;
	localparam logic [CFG_IW-1:0] REG_MAGIC_LENGTH = 1'b1;

	// field widths
	localparam int BYTE_W = 8;
	localparam int WORD_W = 12;
	localparam int KIND_W = 3;
	localparam int CNT_W = 32;
	localparam int OUT_LVL_W = 9;
	localparam int STAT_W = 3;
	localparam int IN_DW = 24;
	localparam int OUT_DW = 192;

	// received word flag bits
	localparam int BIT_FRAMING = 8;
	localparam int BIT_BREAK = 10;
	localparam int BIT_OVERRUN = 11;

	typedef enum logic [KIND_W-1:0] {
		KIND_RX_WORD = 3'd0,
		KIND_READ    = 3'd1,
		KIND_PEEK    = 3'd2,
		KIND_WRITE   = 3'd3,
		KIND_TX_FREE = 3'd4,
		KIND_CLEAR   = 3'd5
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		ERR_NONE    = 3'd0,
		ERR_BREAK   = 3'd1,
		ERR_OVERRUN = 3'd2,
		ERR_FRAMING = 3'd3,
		ERR_FULL    = 3'd4
	} err_t;

	// counter slots
	localparam int CNT_NUM = 5;
	localparam int CNT_BREAK = 0;
	localparam int CNT_OVERRUN = 1;
	localparam int CNT_FRAMING = 2;
	localparam int CNT_RXFULL = 3;
	localparam int CNT_TXFULL = 4;

	typedef enum logic [1:0] {
		DSEL_NONE = 2'd0,
		DSEL_RX   = 2'd1,
		DSEL_TX   = 2'd2
	} dsel_t;

	// everything of a result but the data byte and its valid flag
	typedef struct packed {
		logic                 write_accepted;
		logic                 magic_seen;
		err_t                 rx_status;
		logic [OUT_LVL_W-1:0] rx_fill;
		logic [OUT_LVL_W-1:0] tx_space;
		logic [CNT_W-1:0]     break_total;
		logic [CNT_W-1:0]     overrun_total;
		logic [CNT_W-1:0]     framing_total;
		logic [CNT_W-1:0]     rx_full_total;
		logic [CNT_W-1:0]     tx_full_total;
	} res_t;

endpackage

// ===== src/urtr_ram.sv =====
module urtr_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/urtr_scan.sv =====
module urtr_scan (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [urtr_pkg::CFG_IW-1:0]   cfg_index,
	input  logic [urtr_pkg::CFG_DW-1:0]   cfg_data,
	input  logic                          byte_en,
	input  logic [urtr_pkg::BYTE_W-1:0]   rx_byte,
	output logic                          seen
);

	logic [urtr_pkg::CFG_DW-1:0]      magic_chars_q;
	logic [urtr_pkg::MAGIC_LEN_W-1:0] magic_len_q;
	logic [urtr_pkg::MAGIC_LEN_W-1:0] pos_q;
	logic [urtr_pkg::MAGIC_LEN_W-1:0] len;
	logic [urtr_pkg::MAGIC_LEN_W-1:0] pos0;
	logic [urtr_pkg::MAGIC_LEN_W-1:0] pos_inc;
	logic [urtr_pkg::MAGIC_LEN_W-1:0] pos_nxt;
	logic [urtr_pkg::BYTE_W-1:0]      want;
	logic                             hit;
	logic                             done;

	// lengths above the cap behave as the cap
	assign len = (magic_len_q > urtr_pkg::MAGIC_LEN_CAP) ? urtr_pkg::MAGIC_LEN_CAP : magic_len_q;
	assign pos0 = (pos_q >= len) ? '0 : pos_q;
	assign want = magic_chars_q[{pos0[2:0], 3'b000} +: urtr_pkg::BYTE_W];
	assign hit = (len != '0) && (rx_byte == want);
	assign pos_inc = pos0 + 1'b1;
	assign done = hit && (pos_inc >= len);

	always_comb begin
		if (len == '0) begin
			pos_nxt = pos_q;
		end else if (hit && !done) begin
			pos_nxt = pos_inc;
		end else begin
			pos_nxt = '0;
		end
	end

	assign seen = byte_en && done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_chars_q <= '0;
			magic_len_q <= '0;
			pos_q <= '0;
		end else if (cfg_we) begin
			pos_q <= '0;
			if (cfg_index == urtr_pkg::REG_MAGIC_CHARS) begin
				magic_chars_q <= cfg_data;
			end else begin
				magic_len_q <= cfg_data[urtr_pkg::MAGIC_LEN_W-1:0];
			end
		end else if (byte_en) begin
			pos_q <= pos_nxt;
		end
	end

endmodule

// ===== src/uart_rx_tx_ring_engine.sv =====
// a result passes through stage s1 and then the output register after its item is accepted
// throughput: one item per cycle while the master side does not stall; ring state and
// counters settle at the accept edge, as does the ring memory read register for stage s1
// reset: arst_n clears pointers, levels, counters, status, scanner and handshake state
// at once; ring memories are not cleared, the ring levels keep stale entries unread
module uart_rx_tx_ring_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	// slave side, tdata: kind[2:0], rx_word[14:3], tx_byte[22:15], zero pad
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [urtr_pkg::IN_DW-1:0]    s_tdata,
	// master side, tdata: data_out[7:0], data_valid[8], write_accepted[9],
	// magic_seen[10], rx_status[13:11], rx_fill[22:14], tx_space[31:23],
	// break_total[63:32], overrun_total[95:64], framing_total[127:96],
	// rx_full_total[159:128], tx_full_total[191:160]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [urtr_pkg::OUT_DW-1:0]   m_tdata,
	// register write port
	input  logic                          cfg_we,
	input  logic [urtr_pkg::CFG_IW-1:0]   cfg_index,
	input  logic [urtr_pkg::CFG_DW-1:0]   cfg_data
);

	`include "uart_rx_tx_ring_engine_assert.svh"

	// input fields
	logic [urtr_pkg::KIND_W-1:0] in_kind;
	logic [urtr_pkg::WORD_W-1:0] in_word;
	logic [urtr_pkg::BYTE_W-1:0] in_txb;

	assign in_kind = s_tdata[2:0];
	assign in_word = s_tdata[14:3];
	assign in_txb = s_tdata[22:15];

	// ring pointers and levels
	logic [urtr_pkg::RX_AW-1:0] rx_head_q, rx_tail_q;
	logic [urtr_pkg::RX_LW-1:0] rx_level_q;
	logic [urtr_pkg::TX_AW-1:0] tx_head_q, tx_tail_q;
	logic [urtr_pkg::TX_LW-1:0] tx_level_q;
	urtr_pkg::err_t             first_error_q;
	logic [urtr_pkg::CNT_W-1:0] cnt_q [urtr_pkg::CNT_NUM];

	logic [urtr_pkg::RX_AW-1:0] rx_head_nxt, rx_tail_nxt;
	logic [urtr_pkg::RX_LW-1:0] rx_level_nxt;
	logic [urtr_pkg::TX_AW-1:0] tx_head_nxt, tx_tail_nxt;
	logic [urtr_pkg::TX_LW-1:0] tx_level_nxt;
	urtr_pkg::err_t             first_error_nxt;
	urtr_pkg::err_t             word_class;
	logic [urtr_pkg::CNT_W-1:0] cnt_nxt [urtr_pkg::CNT_NUM];

	logic           acc;
	logic           rx_push, rx_rd, tx_push, tx_pop, accepted;
	logic           seen;
	urtr_pkg::dsel_t dsel;

	// pipeline handshake
	logic           valid_s1;
	logic           adv_s1;
	urtr_pkg::res_t res_s1;
	urtr_pkg::dsel_t dsel_s1;
	logic [urtr_pkg::BYTE_W-1:0] rx_rdata, tx_rdata;
	logic [urtr_pkg::BYTE_W-1:0] data_s1;
	logic           m_valid_q;
	logic [urtr_pkg::OUT_DW-1:0] m_data_q;

	assign adv_s1 = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;
	assign acc = s_tvalid && s_tready;

	// break over overrun over framing, parity ignored
	always_comb begin
		if (in_word[urtr_pkg::BIT_BREAK]) begin
			word_class = urtr_pkg::ERR_BREAK;
		end else if (in_word[urtr_pkg::BIT_OVERRUN]) begin
			word_class = urtr_pkg::ERR_OVERRUN;
		end else if (in_word[urtr_pkg::BIT_FRAMING]) begin
			word_class = urtr_pkg::ERR_FRAMING;
		end else begin
			word_class = urtr_pkg::ERR_NONE;
		end
	end

	// next ring state for the item at the slave side
	always_comb begin
		rx_head_nxt = rx_head_q;
		rx_tail_nxt = rx_tail_q;
		rx_level_nxt = rx_level_q;
		tx_head_nxt = tx_head_q;
		tx_tail_nxt = tx_tail_q;
		tx_level_nxt = tx_level_q;
		first_error_nxt = first_error_q;
		for (int i = 0; i < urtr_pkg::CNT_NUM; i++) begin
			cnt_nxt[i] = cnt_q[i];
		end
		rx_push = 1'b0;
		rx_rd = 1'b0;
		tx_push = 1'b0;
		tx_pop = 1'b0;
		accepted = 1'b0;
		dsel = urtr_pkg::DSEL_NONE;
		case (urtr_pkg::kind_t'(in_kind))
			urtr_pkg::KIND_RX_WORD: begin
				case (word_class)
					urtr_pkg::ERR_BREAK:
						cnt_nxt[urtr_pkg::CNT_BREAK] = cnt_q[urtr_pkg::CNT_BREAK] + 1'b1;
					urtr_pkg::ERR_OVERRUN:
						cnt_nxt[urtr_pkg::CNT_OVERRUN] = cnt_q[urtr_pkg::CNT_OVERRUN] + 1'b1;
					urtr_pkg::ERR_FRAMING:
						cnt_nxt[urtr_pkg::CNT_FRAMING] = cnt_q[urtr_pkg::CNT_FRAMING] + 1'b1;
					default: ;
				endcase
				if (first_error_q == urtr_pkg::ERR_NONE) begin
					first_error_nxt = word_class;
				end
				if (rx_level_q != urtr_pkg::RX_FULL_LVL) begin
					rx_push = 1'b1;
					rx_tail_nxt = (rx_tail_q == urtr_pkg::RX_LAST) ? '0 : rx_tail_q + 1'b1;
					rx_level_nxt = rx_level_q + 1'b1;
				end else begin
					cnt_nxt[urtr_pkg::CNT_RXFULL] = cnt_q[urtr_pkg::CNT_RXFULL] + 1'b1;
					if (first_error_nxt == urtr_pkg::ERR_NONE) begin
						first_error_nxt = urtr_pkg::ERR_FULL;
					end
				end
			end
			urtr_pkg::KIND_READ, urtr_pkg::KIND_PEEK: begin
				if (rx_level_q != '0) begin
					rx_rd = 1'b1;
					dsel = urtr_pkg::DSEL_RX;
					if (urtr_pkg::kind_t'(in_kind) == urtr_pkg::KIND_READ) begin
						rx_head_nxt = (rx_head_q == urtr_pkg::RX_LAST) ? '0 : rx_head_q + 1'b1;
						rx_level_nxt = rx_level_q - 1'b1;
					end
				end
			end
			urtr_pkg::KIND_WRITE: begin
				if (tx_level_q != urtr_pkg::TX_FULL_LVL) begin
					tx_push = 1'b1;
					accepted = 1'b1;
					tx_tail_nxt = (tx_tail_q == urtr_pkg::TX_LAST) ? '0 : tx_tail_q + 1'b1;
					tx_level_nxt = tx_level_q + 1'b1;
				end else begin
					cnt_nxt[urtr_pkg::CNT_TXFULL] = cnt_q[urtr_pkg::CNT_TXFULL] + 1'b1;
				end
			end
			urtr_pkg::KIND_TX_FREE: begin
				if (tx_level_q != '0) begin
					tx_pop = 1'b1;
					dsel = urtr_pkg::DSEL_TX;
					tx_head_nxt = (tx_head_q == urtr_pkg::TX_LAST) ? '0 : tx_head_q + 1'b1;
					tx_level_nxt = tx_level_q - 1'b1;
				end
			end
			urtr_pkg::KIND_CLEAR: begin
				// rx ring and counters only; status, tx ring and scanner stay
				rx_head_nxt = '0;
				rx_tail_nxt = '0;
				rx_level_nxt = '0;
				for (int i = 0; i < urtr_pkg::CNT_NUM; i++) begin
					cnt_nxt[i] = '0;
				end
			end
			default: ;
		endcase
	end

	// magic scanner sees only bytes that made it into the rx ring
	urtr_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.byte_en   (acc && rx_push),
		.rx_byte   (in_word[urtr_pkg::BYTE_W-1:0]),
		.seen      (seen)
	);

	// ring storage, read data lands alongside stage s1
	urtr_ram #(
		.DEPTH (urtr_pkg::RX_DEPTH),
		.WIDTH (urtr_pkg::BYTE_W)
	) u_rx_ram (
		.clk   (clk),
		.we    (acc && rx_push),
		.waddr (rx_tail_q),
		.wdata (in_word[urtr_pkg::BYTE_W-1:0]),
		.re    (acc && rx_rd),
		.raddr (rx_head_q),
		.rdata (rx_rdata)
	);

	urtr_ram #(
		.DEPTH (urtr_pkg::TX_DEPTH),
		.WIDTH (urtr_pkg::BYTE_W)
	) u_tx_ram (
		.clk   (clk),
		.we    (acc && tx_push),
		.waddr (tx_tail_q),
		.wdata (in_txb),
		.re    (acc && tx_pop),
		.raddr (tx_head_q),
		.rdata (tx_rdata)
	);

	// state update at the accept edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_head_q <= '0;
			rx_tail_q <= '0;
			rx_level_q <= '0;
			tx_head_q <= '0;
			tx_tail_q <= '0;
			tx_level_q <= '0;
			first_error_q <= urtr_pkg::ERR_NONE;
			for (int i = 0; i < urtr_pkg::CNT_NUM; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (acc) begin
			rx_head_q <= rx_head_nxt;
			rx_tail_q <= rx_tail_nxt;
			rx_level_q <= rx_level_nxt;
			tx_head_q <= tx_head_nxt;
			tx_tail_q <= tx_tail_nxt;
			tx_level_q <= tx_level_nxt;
			first_error_q <= first_error_nxt;
			for (int i = 0; i < urtr_pkg::CNT_NUM; i++) begin
				cnt_q[i] <= cnt_nxt[i];
			end
		end
	end

	// stage s1 snapshot of the result, data byte still in the ram read register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			dsel_s1 <= dsel;
			res_s1.write_accepted <= accepted;
			res_s1.magic_seen <= seen;
			res_s1.rx_status <= first_error_nxt;
			res_s1.rx_fill <= urtr_pkg::OUT_LVL_W'(rx_level_nxt);
			res_s1.tx_space <= urtr_pkg::OUT_LVL_W'(urtr_pkg::TX_FULL_LVL - tx_level_nxt);
			res_s1.break_total <= cnt_nxt[urtr_pkg::CNT_BREAK];
			res_s1.overrun_total <= cnt_nxt[urtr_pkg::CNT_OVERRUN];
			res_s1.framing_total <= cnt_nxt[urtr_pkg::CNT_FRAMING];
			res_s1.rx_full_total <= cnt_nxt[urtr_pkg::CNT_RXFULL];
			res_s1.tx_full_total <= cnt_nxt[urtr_pkg::CNT_TXFULL];
		end
	end

	always_comb begin
		case (dsel_s1)
			urtr_pkg::DSEL_RX: data_s1 = rx_rdata;
			urtr_pkg::DSEL_TX: data_s1 = tx_rdata;
			default:           data_s1 = '0;
		endcase
	end

	// output register, holds while the master side stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv_s1) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			m_data_q <= {res_s1.tx_full_total, res_s1.rx_full_total, res_s1.framing_total,
				res_s1.overrun_total, res_s1.break_total, res_s1.tx_space, res_s1.rx_fill,
				res_s1.rx_status, res_s1.magic_seen, res_s1.write_accepted,
				(dsel_s1 != urtr_pkg::DSEL_NONE), data_s1};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = m_data_q;

	// ring levels never pass the depth
	`URTR_ASSERT(a_rx_level_bound, rx_level_q <= urtr_pkg::RX_FULL_LVL, "rx level above depth")
	`URTR_ASSERT(a_tx_level_bound, tx_level_q <= urtr_pkg::TX_FULL_LVL, "tx level above depth")
	// once an error is latched it sticks until reset
	`URTR_ASSERT_NEXT(a_status_sticky, first_error_q != urtr_pkg::ERR_NONE,
		$stable(first_error_q), "first error status changed")
	// a read of a non-empty rx ring drops the level by one
	`URTR_ASSERT_NEXT(a_rx_read_pops,
		acc && (urtr_pkg::kind_t'(in_kind) == urtr_pkg::KIND_READ) && (rx_level_q != '0),
		(rx_level_q + 1'b1) == $past(rx_level_q), "rx read did not pop")
	// stage s1 cannot take a new item while a stalled one still sits there
	`URTR_ASSERT(a_no_overwrite, !(valid_s1 && !adv_s1 && acc), "stage s1 overwritten")

endmodule

// ===== dv/tb_uart_rx_tx_ring_engine.sv =====
`timescale 1ns / 100ps

module tb_uart_rx_tx_ring_engine;
	import urtr_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int TAIL_CYCLES = 8;
	localparam int MAX_REPORTS = 10;
	// kind codes beyond the defined events, the block must ignore them
	localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
	localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

	typedef enum int {MODE_MIX, MODE_FILL, MODE_DRAIN} traffic_mode_t;

	// one slave side transfer, lowest bit up: kind, rx_word, tx_byte, zero pad
	typedef struct packed {
		logic              pad;
		logic [BYTE_W-1:0] tx_byte;
		logic [WORD_W-1:0] rx_word;
		kind_t             kind;
	} uart_evt_t;

	// one master side transfer, declared msb first so it maps onto m_tdata
	typedef struct packed {
		logic [CNT_W-1:0]     tx_full_total;
		logic [CNT_W-1:0]     rx_full_total;
		logic [CNT_W-1:0]     framing_total;
		logic [CNT_W-1:0]     overrun_total;
		logic [CNT_W-1:0]     break_total;
		logic [OUT_LVL_W-1:0] tx_space;
		logic [OUT_LVL_W-1:0] rx_fill;
		err_t                 rx_status;
		logic                 magic_seen;
		logic                 write_accepted;
		logic                 data_valid;
		logic [BYTE_W-1:0]    data_out;
	} evt_outcome_t;

	typedef struct {
		uart_evt_t    evt;
		bit           typed;
		evt_outcome_t want;
	} directed_row_t;

	typedef struct {
		logic [CFG_DW-1:0]      chars;
		logic [MAGIC_LEN_W-1:0] len;
		int                     count;
		traffic_mode_t          mode;
	} phase_t;

	// dut hookup, every input known from time zero
	logic                clk;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	// kind[2:0], rx_word[14:3], tx_byte[22:15], zero pad
	logic [IN_DW-1:0]    s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	// data_out, data_valid, write_accepted, magic_seen, rx_status, rx_fill,
	// tx_space, then the five 32-bit totals (break, overrun, framing, rx full, tx full)
	logic [OUT_DW-1:0]   m_tdata;
	logic                cfg_we = 1'b0;
	logic [CFG_IW-1:0]   cfg_index = '0;
	logic [CFG_DW-1:0]   cfg_data = '0;

	uart_rx_tx_ring_engine u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// predictor state: both rings, scanner, sticky status, event totals
	logic [BYTE_W-1:0]      rx_ring [RX_DEPTH];
	logic [BYTE_W-1:0]      tx_ring [TX_DEPTH];
	logic [RX_AW-1:0]       rx_rd, rx_wr;
	logic [TX_AW-1:0]       tx_rd, tx_wr;
	int unsigned            rx_held, tx_held;
	logic [MAGIC_LEN_W-1:0] scan_pos;
	err_t                   sticky_err;
	logic [CNT_W-1:0]       event_totals [CNT_NUM];
	logic [CFG_DW-1:0]      magic_bytes;
	logic [MAGIC_LEN_W-1:0] magic_len;

	// bookkeeping
	evt_outcome_t awaited_outcomes [$];
	int           mismatch_count = 0;
	int           results_seen = 0;
	int           events_sent = 0;
	int           cycle_count = 0;
	int           magic_hits = 0;
	int           rx_drops = 0;
	int           tx_refusals = 0;
	int unsigned  feed_idx = 0;
	bit           src_gaps = 1'b0;
	bit           sink_gaps = 1'b0;
	bit           hold_off_req = 1'b0;

	// lengths above the cap behave as the cap
	function automatic int unsigned active_len();
		return (magic_len > MAGIC_LEN_CAP) ? MAGIC_MAX : int'(magic_len);
	endfunction

	function automatic void log_rx_fault(err_t code, int slot);
		event_totals[slot]++;
		if (sticky_err == ERR_NONE)
			sticky_err = code;
	endfunction

	// a mismatching byte restarts the scan and is not tried against the first magic byte
	function automatic logic scan_stored(logic [BYTE_W-1:0] b);
		int unsigned len;
		logic [BYTE_W-1:0] want;
		len = active_len();
		if (len == 0)
			return 1'b0;
		if (scan_pos >= len)
			scan_pos = '0;
		want = magic_bytes[BYTE_W * scan_pos[2:0] +: BYTE_W];
		if (b != want) begin
			scan_pos = '0;
			return 1'b0;
		end
		scan_pos++;
		if (scan_pos < len)
			return 1'b0;
		scan_pos = '0;
		return 1'b1;
	endfunction

	// applies one event to the predictor and returns the result it must produce
	function automatic evt_outcome_t ring_engine_step(uart_evt_t e);
		evt_outcome_t o;
		o = '0;
		case (e.kind)
			KIND_RX_WORD: begin
				// break beats overrun beats framing, parity is ignored
				if (e.rx_word[BIT_BREAK])
					log_rx_fault(ERR_BREAK, CNT_BREAK);
				else if (e.rx_word[BIT_OVERRUN])
					log_rx_fault(ERR_OVERRUN, CNT_OVERRUN);
				else if (e.rx_word[BIT_FRAMING])
					log_rx_fault(ERR_FRAMING, CNT_FRAMING);
				if (rx_held < RX_DEPTH) begin
					rx_ring[rx_wr] = e.rx_word[BYTE_W-1:0];
					rx_wr++;
					rx_held++;
					o.magic_seen = scan_stored(e.rx_word[BYTE_W-1:0]);
					magic_hits += o.magic_seen;
				end else begin
					// dropped byte never reaches the scanner
					log_rx_fault(ERR_FULL, CNT_RXFULL);
					rx_drops++;
				end
			end
			KIND_READ, KIND_PEEK: begin
				if (rx_held > 0) begin
					o.data_out = rx_ring[rx_rd];
					o.data_valid = 1'b1;
					if (e.kind == KIND_READ) begin
						rx_rd++;
						rx_held--;
					end
				end
			end
			KIND_WRITE: begin
				if (tx_held < TX_DEPTH) begin
					tx_ring[tx_wr] = e.tx_byte;
					tx_wr++;
					tx_held++;
					o.write_accepted = 1'b1;
				end else begin
					event_totals[CNT_TXFULL]++;
					tx_refusals++;
				end
			end
			KIND_TX_FREE: begin
				if (tx_held > 0) begin
					o.data_out = tx_ring[tx_rd];
					o.data_valid = 1'b1;
					tx_rd++;
					tx_held--;
				end
			end
			KIND_CLEAR: begin
				// sticky status, tx ring and scan position survive a clear
				rx_rd = '0;
				rx_wr = '0;
				rx_held = 0;
				foreach (event_totals[i])
					event_totals[i] = '0;
			end
			default: ;
		endcase
		o.rx_status = sticky_err;
		o.rx_fill = OUT_LVL_W'(rx_held);
		o.tx_space = OUT_LVL_W'(TX_DEPTH - tx_held);
		o.break_total = event_totals[CNT_BREAK];
		o.overrun_total = event_totals[CNT_OVERRUN];
		o.framing_total = event_totals[CNT_FRAMING];
		o.rx_full_total = event_totals[CNT_RXFULL];
		o.tx_full_total = event_totals[CNT_TXFULL];
		return o;
	endfunction

	// mostly clean words; bytes mostly walk the magic sequence so the scanner goes deep
	function automatic logic [WORD_W-1:0] draw_rx_word();
		logic [WORD_W-1:0] w;
		int unsigned len;
		len = active_len();
		if ($urandom_range(0, 99) < 65)
			w[WORD_W-1:BYTE_W] = {2'b00, 1'($urandom_range(0, 1)), 1'b0};
		else
			w[WORD_W-1:BYTE_W] = 4'($urandom_range(0, 15));
		if (len != 0 && $urandom_range(0, 3) != 0) begin
			if (feed_idx >= len)
				feed_idx = 0;
			w[BYTE_W-1:0] = magic_bytes[BYTE_W * feed_idx +: BYTE_W];
			feed_idx = (feed_idx + 1) % len;
		end else begin
			w[BYTE_W-1:0] = 8'($urandom_range(0, 255));
			feed_idx = 0;
		end
		return w;
	endfunction

	function automatic kind_t spare_kind();
		return kind_t'($urandom_range(0, 1) ? KIND_SPARE_LO : KIND_SPARE_HI);
	endfunction

	// event mix per traffic mode
	function automatic uart_evt_t draw_evt(traffic_mode_t mode);
		uart_evt_t e;
		int unsigned pick;
		e = '0;
		pick = $urandom_range(0, 99);
		case (mode)
			MODE_FILL: begin
				// no clears here so both rings reach full
				if (pick < 48)      e.kind = KIND_RX_WORD;
				else if (pick < 95) e.kind = KIND_WRITE;
				else if (pick < 98) e.kind = KIND_PEEK;
				else                e.kind = spare_kind();
			end
			MODE_DRAIN: begin
				if (pick < 42)      e.kind = KIND_READ;
				else if (pick < 92) e.kind = KIND_TX_FREE;
				else if (pick < 94) e.kind = KIND_PEEK;
				else if (pick < 96) e.kind = KIND_CLEAR;
				else if (pick < 98) e.kind = KIND_RX_WORD;
				else                e.kind = KIND_WRITE;
			end
			default: begin
				if (pick < 35)      e.kind = KIND_RX_WORD;
				else if (pick < 58) e.kind = KIND_READ;
				else if (pick < 66) e.kind = KIND_PEEK;
				else if (pick < 80) e.kind = KIND_WRITE;
				else if (pick < 95) e.kind = KIND_TX_FREE;
				else if (pick < 97) e.kind = KIND_CLEAR;
				else                e.kind = spare_kind();
			end
		endcase
		// unused fields carry random content too
		e.rx_word = draw_rx_word();
		e.tx_byte = 8'($urandom_range(0, 255));
		return e;
	endfunction

	function automatic directed_row_t mk_row(kind_t k, logic [WORD_W-1:0] w,
			logic [BYTE_W-1:0] b, bit typed, evt_outcome_t want);
		directed_row_t r;
		r.evt = '0;
		r.evt.kind = k;
		r.evt.rx_word = w;
		r.evt.tx_byte = b;
		r.typed = typed;
		r.want = want;
		return r;
	endfunction

	// offers one event, waits for its transfer, then queues what it must produce
	task automatic send_evt(uart_evt_t e, bit typed, evt_outcome_t want);
		evt_outcome_t predicted;
		if (src_gaps && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= e;
		do @(posedge clk); while (!s_tready);
		predicted = ring_engine_step(e);
		awaited_outcomes.push_back(typed ? want : predicted);
		events_sent++;
	endtask

	// writes both scanner registers on consecutive edges, block must be idle
	task automatic program_scanner(logic [CFG_DW-1:0] chars, logic [MAGIC_LEN_W-1:0] len);
		cfg_we <= 1'b1;
		cfg_index <= REG_MAGIC_CHARS;
		cfg_data <= chars;
		@(posedge clk);
		magic_bytes = chars;
		scan_pos = '0;
		cfg_index <= REG_MAGIC_LENGTH;
		cfg_data <= CFG_DW'(len);
		@(posedge clk);
		magic_len = len;
		scan_pos = '0;
		feed_idx = 0;
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (awaited_outcomes.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	function automatic void note_mismatch(string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%s", msg);
	endfunction

	function automatic void check_field(string name, logic [CNT_W-1:0] want,
			logic [CNT_W-1:0] got);
		if (want !== got)
			note_mismatch($sformatf("result %0d %s: expected 0x%0h, got 0x%0h",
				results_seen, name, want, got));
	endfunction

	// receiver: random ready gaps, plus one long hold-off on request
	initial begin : sink
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
				m_tready <= 1'b1;
			end else if (sink_gaps && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// every master side transfer against the oldest queued outcome
	initial begin : result_check
		evt_outcome_t got, want;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				got = evt_outcome_t'(m_tdata);
				results_seen++;
				if (awaited_outcomes.size() == 0) begin
					note_mismatch($sformatf("result %0d arrived with nothing outstanding",
						results_seen));
				end else begin
					want = awaited_outcomes.pop_front();
					check_field("data_out", want.data_out, got.data_out);
					check_field("data_valid", want.data_valid, got.data_valid);
					check_field("write_accepted", want.write_accepted, got.write_accepted);
					check_field("magic_seen", want.magic_seen, got.magic_seen);
					check_field("rx_status", want.rx_status, got.rx_status);
					check_field("rx_fill", want.rx_fill, got.rx_fill);
					check_field("tx_space", want.tx_space, got.tx_space);
					check_field("break_total", want.break_total, got.break_total);
					check_field("overrun_total", want.overrun_total, got.overrun_total);
					check_field("framing_total", want.framing_total, got.framing_total);
					check_field("rx_full_total", want.rx_full_total, got.rx_full_total);
					check_field("tx_full_total", want.tx_full_total, got.tx_full_total);
				end
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results outstanding",
			cycle_count, awaited_outcomes.size());
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : stimulus
		directed_row_t rows [$];
		phase_t        phases [4];
		evt_outcome_t  quiet, after;
		bit            last;

		// predictor starts from the reset state
		rx_rd = '0;
		rx_wr = '0;
		tx_rd = '0;
		tx_wr = '0;
		rx_held = 0;
		tx_held = 0;
		scan_pos = '0;
		sticky_err = ERR_NONE;
		foreach (event_totals[i])
			event_totals[i] = '0;
		magic_bytes = '0;
		magic_len = '0;

		// directed table, fresh block with magic sequence 41 42 43
		quiet = '0;
		quiet.rx_status = ERR_NONE;
		quiet.tx_space = OUT_LVL_W'(TX_DEPTH);
		// empty rings and ignored kinds report status only
		rows.push_back(mk_row(KIND_READ, 12'h000, 8'h00, 1'b1, quiet));
		rows.push_back(mk_row(KIND_PEEK, 12'h000, 8'h00, 1'b1, quiet));
		rows.push_back(mk_row(KIND_TX_FREE, 12'h000, 8'h00, 1'b1, quiet));
		rows.push_back(mk_row(kind_t'(KIND_SPARE_LO), 12'hFFF, 8'hFF, 1'b1, quiet));
		rows.push_back(mk_row(kind_t'(KIND_SPARE_HI), 12'hFFF, 8'hFF, 1'b1, quiet));
		// all flags set: break wins and becomes the sticky status
		after = quiet;
		after.rx_status = ERR_BREAK;
		after.rx_fill = 1;
		after.break_total = 1;
		rows.push_back(mk_row(KIND_RX_WORD, 12'hFFF, 8'h00, 1'b1, after));
		// overrun over framing, status stays break
		after.rx_fill = 2;
		after.overrun_total = 1;
		rows.push_back(mk_row(KIND_RX_WORD, 12'h900, 8'h00, 1'b1, after));
		after.rx_fill = 3;
		after.framing_total = 1;
		rows.push_back(mk_row(KIND_RX_WORD, 12'h155, 8'h00, 1'b1, after));
		// parity alone counts nothing
		after.rx_fill = 4;
		rows.push_back(mk_row(KIND_RX_WORD, 12'h2AA, 8'h00, 1'b1, after));
		rows.push_back(mk_row(KIND_PEEK, 12'h000, 8'h00, 1'b0, quiet));
		rows.push_back(mk_row(KIND_READ, 12'h000, 8'h00, 1'b0, quiet));
		// mismatch restart: A A B C never completes
		rows.push_back(mk_row(KIND_RX_WORD, 12'h041, 8'h00, 1'b0, quiet));
		rows.push_back(mk_row(KIND_RX_WORD, 12'h041, 8'h00, 1'b0, quiet));
		rows.push_back(mk_row(KIND_RX_WORD, 12'h042, 8'h00, 1'b0, quiet));
		rows.push_back(mk_row(KIND_RX_WORD, 12'h043, 8'h00, 1'b0, quiet));
		// clean A B C completes the sequence
		rows.push_back(mk_row(KIND_RX_WORD, 12'h041, 8'h00, 1'b0, quiet));
		rows.push_back(mk_row(KIND_RX_WORD, 12'h042, 8'h00, 1'b0, quiet));
		rows.push_back(mk_row(KIND_RX_WORD, 12'h043, 8'h00, 1'b0, quiet));
		// tx ring round trip, third pop finds it empty
		rows.push_back(mk_row(KIND_WRITE, 12'hFFF, 8'h00, 1'b0, quiet));
		rows.push_back(mk_row(KIND_WRITE, 12'h000, 8'hFF, 1'b0, quiet));
		rows.push_back(mk_row(KIND_TX_FREE, 12'h000, 8'h00, 1'b0, quiet));
		rows.push_back(mk_row(KIND_TX_FREE, 12'h000, 8'h00, 1'b0, quiet));
		rows.push_back(mk_row(KIND_TX_FREE, 12'h000, 8'h00, 1'b0, quiet));
		// clear keeps the sticky status, then the rx ring reads empty
		rows.push_back(mk_row(KIND_CLEAR, 12'hFFF, 8'hFF, 1'b0, quiet));
		rows.push_back(mk_row(KIND_READ, 12'h000, 8'h00, 1'b0, quiet));

		// random phases: mixed traffic, fill both rings past full, drain, mixed again
		phases[0] = '{{$urandom, $urandom}, 4'd12, 250, MODE_MIX};
		phases[1] = '{64'h0, 4'd0, 650, MODE_FILL};
		phases[2] = '{64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 550, MODE_DRAIN};
		phases[3] = '{{$urandom, $urandom}, 4'($urandom_range(1, 7)), 300, MODE_MIX};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		program_scanner(64'h0000_0000_0043_4241, 4'd3);
		foreach (rows[i])
			send_evt(rows[i].evt, rows[i].typed, rows[i].want);

		foreach (phases[p]) begin
			wait_drained();
			program_scanner(phases[p].chars, phases[p].len);
			last = (p == $size(phases) - 1);
			for (int n = 0; n < phases[p].count; n++) begin
				// gaps come and go in stretches, none in the closing phase
				if (n % 64 == 0) begin
					src_gaps = !last && $urandom_range(0, 2) != 0;
					sink_gaps = !last && $urandom_range(0, 2) != 0;
				end
				// receiver stalls long while the sender keeps offering
				if (phases[p].mode == MODE_FILL && n == 20)
					hold_off_req = 1'b1;
				send_evt(draw_evt(phases[p].mode), 1'b0, '0);
			end
		end
		wait_drained();

		$display("%0d events sent, %0d results checked in %0d cycles, %0d mismatches",
			events_sent, results_seen, cycle_count, mismatch_count);
		$display("magic hits %0d, rx bytes dropped on full ring %0d, tx writes refused %0d",
			magic_hits, rx_drops, tx_refusals);
		if (mismatch_count == 0 && awaited_outcomes.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
